@@ design/bilinear_relation_engine_defines.svh @@
// ---------------------------------------------------------------------------
// Bilinear relation engine assertion macros
// Shared concurrent assertion forms, clocked and disabled by the caller's
// clock and reset.
// ---------------------------------------------------------------------------
`ifndef BILINEAR_RELATION_ENGINE_DEFINES_SVH
`define BILINEAR_RELATION_ENGINE_DEFINES_SVH

// same-cycle implication
`define BRE_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BRE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/brel_pkg.sv @@
// ---------------------------------------------------------------------------
// brel_pkg
// Types, codes and defaults shared by the bilinear relation engine.
// ---------------------------------------------------------------------------
package brel_pkg;

  localparam int DEF_MAX_OBJECTS = 256;
  localparam int DEF_MAX_DIMS    = 64;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_ARITY   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OBJECTS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIMS    = 2'd2;

  localparam logic [1:0] ARITY_UNARY = 2'd1;

  // unary assert scales v by 128 = round(v * 2^13 / 2^6)
  localparam logic signed [15:0] UNARY_SCALE = 16'sd8192;

  typedef enum logic [1:0] {
    ACT_WRITE  = 2'd0,
    ACT_ASSERT = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_NONE   = 2'd3
  } brel_action_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } brel_state_t;

  typedef struct packed {
    logic clear;
    logic capture;
    logic emb_write;
    logic issue;
    logic finish;
  } brel_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic trivial;
    logic issue_last;
    logic pipe_busy;
  } brel_stat_t;

endpackage

@@ design/bilinear_relation_engine.sv @@
// ---------------------------------------------------------------------------
// bilinear_relation_engine
// Embedding table plus one relation matrix; writes embeddings, asserts
// tuples (outer-product update if binary) and scores tuples (bilinear form if binary).
// ---------------------------------------------------------------------------
//
//   channel | signals                                  | handshake
//   --------+------------------------------------------+---------------------
//   command | action first_object second_object        | start && !busy
//           | element value                            |
//   result  | score status                             | done, one cycle
//   config  | cfg_index cfg_data                       | cfg_write
//
// Flow: an embedding write, a rejected or empty transaction goes from accept
// through decode straight to finish and done. Assert and query step through
// d*d (binary) or d (unary) matrix entries, d being the active dimension count,
// then drain the pipeline before done. Loop issue runs one multiply-accumulate
// per cycle through the single relation-memory read port.
// Reset: after rst the relation matrix is swept to zero, one entry a cycle,
// over all MAX_DIMS*MAX_DIMS entries (4096 by default) with busy held high.
// The receiver cannot stall: done is a one-cycle strobe.
// ---------------------------------------------------------------------------
module bilinear_relation_engine #(
  parameter int MAX_OBJECTS = brel_pkg::DEF_MAX_OBJECTS,
  parameter int MAX_DIMS    = brel_pkg::DEF_MAX_DIMS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      action,
  input  logic [7:0]                      first_object,
  input  logic [7:0]                      second_object,
  input  logic [5:0]                      element,
  input  logic signed [15:0]              value,
  output logic                            done,
  output logic signed [47:0]              score,
  output logic                            status,
  input  logic                            cfg_write,
  input  logic [brel_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [brel_pkg::CFG_DATA_W-1:0] cfg_data
);

  // controller commands and datapath status
  brel_pkg::brel_cmd_t  cmd;
  brel_pkg::brel_stat_t stat;

  brel_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // memories, config registers and the MAC pipeline
  brel_datapath #(
    .MAX_OBJECTS (MAX_OBJECTS),
    .MAX_DIMS    (MAX_DIMS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .action        (action),
    .first_object  (first_object),
    .second_object (second_object),
    .element       (element),
    .value         (value),
    .done          (done),
    .score         (score),
    .status        (status)
  );

endmodule

@@ design/brel_ctrl.sv @@
// ---------------------------------------------------------------------------
// brel_ctrl
// Sequencer: matrix clear after reset, decode, loop issue, drain, result.
// ---------------------------------------------------------------------------
`include "bilinear_relation_engine_defines.svh"

module brel_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  brel_pkg::brel_stat_t stat,
  output brel_pkg::brel_cmd_t  cmd,
  output logic                busy
);

  brel_pkg::brel_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= brel_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      brel_pkg::ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_last) state_next = brel_pkg::ST_IDLE;
      end
      brel_pkg::ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = brel_pkg::ST_DECODE;
        end
      end
      brel_pkg::ST_DECODE: begin
        if (stat.trivial) begin
          cmd.emb_write = 1'b1;
          state_next    = brel_pkg::ST_FINISH;
        end else begin
          state_next = brel_pkg::ST_RUN;
        end
      end
      brel_pkg::ST_RUN: begin
        cmd.issue = 1'b1;
        if (stat.issue_last) state_next = brel_pkg::ST_DRAIN;
      end
      brel_pkg::ST_DRAIN: begin
        if (!stat.pipe_busy) state_next = brel_pkg::ST_FINISH;
      end
      brel_pkg::ST_FINISH: begin
        cmd.finish = 1'b1;
        state_next = brel_pkg::ST_IDLE;
      end
      default: state_next = brel_pkg::ST_CLEAR;
    endcase
  end

  assign busy = (state != brel_pkg::ST_IDLE);

  `BRE_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy, "accepted item did not raise busy")
  `BRE_ASSERT_SAME(a_issue_alone, clk, rst, cmd.issue, !cmd.finish && !cmd.clear, "issue overlaps finish or clear")
  `BRE_ASSERT_NEXT(a_finish_idle, clk, rst, cmd.finish, !busy, "finish not followed by idle")

endmodule

@@ design/brel_datapath.sv @@
// ---------------------------------------------------------------------------
// brel_datapath
// Embedding and relation memories, config registers, MAC pipeline.
// ---------------------------------------------------------------------------
module brel_datapath #(
  parameter int MAX_OBJECTS = brel_pkg::DEF_MAX_OBJECTS,
  parameter int MAX_DIMS    = brel_pkg::DEF_MAX_DIMS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  brel_pkg::brel_cmd_t                 cmd,
  output brel_pkg::brel_stat_t                stat,
  input  logic                                cfg_write,
  input  logic [brel_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [brel_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [1:0]                          action,
  input  logic [7:0]                          first_object,
  input  logic [7:0]                          second_object,
  input  logic [5:0]                          element,
  input  logic signed [15:0]                  value,
  output logic                                done,
  output logic signed [47:0]                  score,
  output logic                                status
);

  localparam int IW    = $clog2(MAX_DIMS);
  localparam int DW    = $clog2(MAX_DIMS + 1);
  localparam int EDEP  = MAX_OBJECTS * MAX_DIMS;
  localparam int EAW   = $clog2(EDEP);
  localparam int RDEP  = MAX_DIMS * MAX_DIMS;
  localparam int RAW   = $clog2(RDEP);
  localparam int TW    = 48 + IW;

  localparam logic signed [63:0] S48_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] S48_MIN = -64'sh0000_8000_0000_0000;
  localparam logic signed [48:0] S32_MAX = 49'sh0_7FFF_FFFF;
  localparam logic signed [48:0] S32_MIN = -49'sh0_8000_0000;

  // config registers
  logic [1:0] relation_arity;
  logic [8:0] objects_in_use;
  logic [6:0] dims_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      relation_arity <= 2'd2;
      objects_in_use <= 9'd256;
      dims_in_use    <= 7'd64;
    end else if (cfg_write) begin
      unique case (cfg_index)
        brel_pkg::REG_ARITY:   relation_arity <= cfg_data[1:0];
        brel_pkg::REG_OBJECTS: objects_in_use <= cfg_data;
        brel_pkg::REG_DIMS:    dims_in_use    <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // captured transaction
  brel_pkg::brel_action_t act_q;
  logic [7:0]         a_q, b_q;
  logic [5:0]         elem_q;
  logic signed [15:0] val_q;
  logic               binary_q;
  logic [EAW-1:0]     base_a, base_b;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_q    <= brel_pkg::brel_action_t'(action);
      a_q      <= first_object;
      b_q      <= second_object;
      elem_q   <= element;
      val_q    <= value;
      binary_q <= (relation_arity != brel_pkg::ARITY_UNARY);
      base_a   <= EAW'(EAW'(first_object) * EAW'(MAX_DIMS));
      base_b   <= EAW'(EAW'(second_object) * EAW'(MAX_DIMS));
    end
  end

  logic a_ok, b_ok, elem_ok, reject, dims_zero, is_write, is_assert, is_query;
  logic [DW-1:0] d_act;
  logic [IW-1:0] dm1;

  assign a_ok    = ({1'b0, a_q} < objects_in_use) && (32'(a_q) < MAX_OBJECTS);
  assign b_ok    = ({1'b0, b_q} < objects_in_use) && (32'(b_q) < MAX_OBJECTS);
  assign elem_ok = (32'(elem_q) < MAX_DIMS);
  assign d_act   = (32'(dims_in_use) < MAX_DIMS) ? DW'(dims_in_use) : DW'(MAX_DIMS);
  assign dm1     = IW'(d_act - DW'(1));
  assign dims_zero = (d_act == '0);
  assign is_write  = (act_q == brel_pkg::ACT_WRITE);
  assign is_assert = (act_q == brel_pkg::ACT_ASSERT);
  assign is_query  = (act_q == brel_pkg::ACT_QUERY);

  always_comb begin
    unique case (act_q)
      brel_pkg::ACT_WRITE:  reject = !a_ok || !elem_ok;
      brel_pkg::ACT_ASSERT,
      brel_pkg::ACT_QUERY:  reject = !a_ok || (binary_q && !b_ok);
      default:              reject = 1'b0;
    endcase
  end

  assign stat.trivial = is_write || (act_q == brel_pkg::ACT_NONE) || reject || dims_zero;

  // loop counters: ro = row i, co = column j
  logic [IW-1:0] ro, co;
  logic          row_end;

  assign row_end         = (co == dm1);
  assign stat.issue_last = binary_q ? (row_end && ro == dm1) : row_end;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ro <= '0;
      co <= '0;
    end else if (cmd.issue) begin
      if (row_end) begin
        co <= '0;
        ro <= ro + IW'(1);
      end else begin
        co <= co + IW'(1);
      end
    end
  end

  // clear sweep after reset
  logic [RAW-1:0] clr_cnt;
  assign stat.clear_last = (clr_cnt == RAW'(RDEP - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear) begin
      clr_cnt <= clr_cnt + RAW'(1);
    end
  end

  // S0 addresses
  logic [EAW-1:0] emb_addr_a, emb_addr_b, emb_waddr;
  logic [RAW-1:0] rel_raddr;

  always_comb begin
    if (binary_q) begin
      emb_addr_a = base_a + EAW'(ro);
      emb_addr_b = base_b + EAW'(co);
      rel_raddr  = RAW'(RAW'(ro) * RAW'(MAX_DIMS)) + RAW'(co);
    end else begin
      emb_addr_a = base_a + EAW'(co);
      emb_addr_b = base_a + EAW'(co);
      rel_raddr  = RAW'(co);
    end
  end

  assign emb_waddr = base_a + EAW'(elem_q);

  // embedding memory: one write, two registered reads
  logic signed [15:0] emb_mem [EDEP];
  logic signed [15:0] emb_rd_a, emb_rd_b;

  always_ff @(posedge clk) begin
    if (cmd.emb_write && is_write && !reject) begin
      emb_mem[emb_waddr] <= val_q;
    end
    emb_rd_a <= emb_mem[emb_addr_a];
    emb_rd_b <= emb_mem[emb_addr_b];
  end

  // relation memory: one write, one registered read
  logic signed [31:0] rel_mem [RDEP];
  logic signed [31:0] rel_rd;
  logic               rel_we;
  logic [RAW-1:0]     rel_waddr;
  logic signed [31:0] rel_wdata;

  always_ff @(posedge clk) begin
    if (rel_we) begin
      rel_mem[rel_waddr] <= rel_wdata;
    end
    rel_rd <= rel_mem[rel_raddr];
  end

  // S1 tags
  logic           v1s, first1, last1;
  logic [RAW-1:0] radr1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1s <= 1'b0;
    end else begin
      v1s <= cmd.issue;
    end
    first1 <= (co == '0);
    last1  <= row_end;
    radr1  <= rel_raddr;
  end

  // S2 multiply
  logic signed [31:0] mx;
  logic signed [15:0] my;
  logic signed [47:0] prod2;
  logic signed [31:0] rold2;
  logic signed [15:0] v1_2;
  logic               v2s, first2, last2;
  logic [RAW-1:0]     radr2;

  assign mx = is_assert ? 32'(emb_rd_a) : rel_rd;
  assign my = is_assert ? (binary_q ? emb_rd_b : brel_pkg::UNARY_SCALE) : emb_rd_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2s <= 1'b0;
    end else begin
      v2s <= v1s;
    end
    prod2  <= mx * my;
    rold2  <= rel_rd;
    v1_2   <= emb_rd_a;
    first2 <= first1;
    last2  <= last1;
    radr2  <= radr1;
  end

  // S3 assert: rounded add with 32-bit saturation, write back
  logic signed [41:0] pround;
  logic signed [48:0] rsum;

  assign pround = 42'(prod2 >>> 6) + 42'($signed({1'b0, prod2[5]}));
  assign rsum   = 49'(rold2) + 49'(pround);

  always_comb begin
    if (cmd.clear) begin
      rel_we    = 1'b1;
      rel_waddr = clr_cnt;
      rel_wdata = '0;
    end else begin
      rel_we    = v2s && is_assert;
      rel_waddr = radr2;
      if (rsum > S32_MAX)      rel_wdata = 32'sh7FFF_FFFF;
      else if (rsum < S32_MIN) rel_wdata = -32'sh8000_0000;
      else                     rel_wdata = rsum[31:0];
    end
  end

  // S3 query: row sum t
  logic signed [TW-1:0] t_acc;
  logic signed [15:0]   v1_3;
  logic                 rowv3;

  always_ff @(posedge clk) begin
    if (rst) begin
      rowv3 <= 1'b0;
    end else begin
      rowv3 <= v2s && last2 && is_query;
    end
    if (v2s) begin
      t_acc <= (first2 ? TW'(0) : t_acc) + TW'(prod2);
    end
    v1_3 <= v1_2;
  end

  // S4 round t (binary only)
  logic signed [TW-1:0] tr4;
  logic signed [15:0]   v1_4;
  logic                 rowv4;

  always_ff @(posedge clk) begin
    if (rst) begin
      rowv4 <= 1'b0;
    end else begin
      rowv4 <= rowv3;
    end
    tr4  <= binary_q ? (t_acc >>> 13) + TW'($signed({1'b0, t_acc[12]})) : t_acc;
    v1_4 <= v1_3;
  end

  // S5 scale by v1[i] (binary only)
  logic signed [TW+15:0] m5;
  logic signed [63:0]    prod5;
  logic                  rowv5;

  assign m5 = tr4 * v1_4;

  always_ff @(posedge clk) begin
    if (rst) begin
      rowv5 <= 1'b0;
    end else begin
      rowv5 <= rowv4;
    end
    prod5 <= binary_q ? $signed(m5[63:0]) : 64'(tr4);
  end

  // S6 accumulate
  logic signed [63:0] acc;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      acc <= '0;
    end else if (rowv5) begin
      acc <= acc + prod5;
    end
  end

  assign stat.pipe_busy = v1s || v2s || rowv3 || rowv4 || rowv5;

  // result
  logic signed [63:0] fin;
  logic signed [47:0] fin_sat;

  assign fin = (acc >>> 13) + 64'($signed({1'b0, acc[12]}));

  always_comb begin
    if (fin > S48_MAX)      fin_sat = 48'sh7FFF_FFFF_FFFF;
    else if (fin < S48_MIN) fin_sat = -48'sh8000_0000_0000;
    else                    fin_sat = fin[47:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
    if (cmd.finish) begin
      score  <= (is_query && !reject) ? fin_sat : '0;
      status <= reject;
    end
  end

endmodule
